@@ sv/grid_bfs_timed_closures_assert.svh @@
`ifndef GRID_BFS_TIMED_CLOSURES_ASSERT_SVH
`define GRID_BFS_TIMED_CLOSURES_ASSERT_SVH

// same-cycle implication and next-cycle implication, both gated by reset
`ifndef ASSERT_OFF
`define GBT_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed");
`define GBT_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define GBT_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define GBT_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

@@ sv/gbt_pkg.sv @@
package gbt_pkg;

	localparam int GRID_DIM_DEF  = 64;
	localparam int HOUR_BITS_DEF = 16;

	localparam int COORD_W   = 6;
	localparam int HOUR_IN_W = 16;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int STATUS_W  = 2;
	localparam int DIST_W    = 12;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
	localparam logic [DIST_W-1:0] DIST_MAX = 12'd4095;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd1;

	localparam logic [STATUS_W-1:0] STAT_FOUND       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_OUT_OF_BNDS = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_START_CLOSE = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_UNREACHABLE = 2'd3;

	localparam logic CMD_SET   = 1'b0;
	localparam logic CMD_ROUTE = 1'b1;

	typedef struct packed {
		logic clear;
		logic seed;
		logic sweep;
		logic commit;
		logic up_ok;
		logic down_ok;
		logic row_ok;
	} cell_ctl_t;

endpackage

@@ sv/gbt_if.sv @@
interface gbt_req_if import gbt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 command;
	logic [COORD_W-1:0]   zone_x;
	logic [COORD_W-1:0]   zone_y;
	logic [HOUR_IN_W-1:0] closing_hour;
	logic [COORD_W-1:0]   start_x;
	logic [COORD_W-1:0]   start_y;
	logic [COORD_W-1:0]   end_x;
	logic [COORD_W-1:0]   end_y;
	modport source (output valid, command, zone_x, zone_y, closing_hour,
		start_x, start_y, end_x, end_y, input ready);
	modport sink (input valid, command, zone_x, zone_y, closing_hour,
		start_x, start_y, end_x, end_y, output ready);
endinterface

interface gbt_res_if import gbt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [DIST_W-1:0]   distance;
	modport source (output valid, status, distance, input ready);
	modport sink (input valid, status, distance, output ready);
endinterface

interface gbt_cfg_if import gbt_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ sv/gbt_row_mem.sv @@
module gbt_row_mem import gbt_pkg::*; #(
	parameter int GRID_DIM  = GRID_DIM_DEF,
	parameter int HOUR_BITS = HOUR_BITS_DEF,
	localparam int RW = $clog2(GRID_DIM),
	localparam int ROW_W = GRID_DIM * HOUR_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [RW-1:0]    rd_addr,
	output logic [ROW_W-1:0] rd_row,
	input  logic             wr_en,
	input  logic [RW-1:0]    wr_addr,
	input  logic [ROW_W-1:0] wr_row
);

	logic [ROW_W-1:0]    mem [GRID_DIM];
	logic [GRID_DIM-1:0] row_vld_q;
	logic [ROW_W-1:0]    rd_data_q;
	logic                rd_vld_q;

	// rows never written read as never-closing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en)
				row_vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= row_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_row;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_row = rd_vld_q ? rd_data_q : '1;

endmodule

@@ sv/gbt_cell.sv @@
module gbt_cell import gbt_pkg::*; #(
	parameter int GRID_DIM  = GRID_DIM_DEF,
	parameter int HOUR_BITS = HOUR_BITS_DEF,
	localparam int RW = $clog2(GRID_DIM)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctl_t            ctl,
	input  logic                 seed_sel,
	input  logic [RW-1:0]        seed_row,
	input  logic                 col_ok,
	input  logic [HOUR_BITS-1:0] hour,
	input  logic [HOUR_BITS-1:0] step_hour,
	input  logic                 left_in,
	input  logic                 right_in,
	output logic                 front_out,
	output logic                 new_out
);

	localparam logic [HOUR_BITS-1:0] NEVER = '1;

	// column bits rotate so that bit 0 is always the row being swept
	logic [GRID_DIM-1:0] fq_q, vq_q, nq_q;
	logic [GRID_DIM-1:0] vq_upd, nq_upd;
	logic                nbr, open, nb;

	assign nbr  = left_in | right_in | (ctl.up_ok & fq_q[GRID_DIM-1]) | (ctl.down_ok & fq_q[1]);
	assign open = (hour == NEVER) || (hour > step_hour);
	assign nb   = nbr & open & col_ok & ctl.row_ok & ~vq_q[0];

	assign vq_upd = {vq_q[GRID_DIM-1:1], vq_q[0] | nb};
	assign nq_upd = {nq_q[GRID_DIM-1:1], nb};

	assign front_out = fq_q[0];
	assign new_out   = ctl.sweep & nb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fq_q <= '0;
			vq_q <= '0;
			nq_q <= '0;
		end else if (ctl.clear) begin
			fq_q <= (ctl.seed && seed_sel) ? (GRID_DIM'(1) << seed_row) : '0;
			vq_q <= (ctl.seed && seed_sel) ? (GRID_DIM'(1) << seed_row) : '0;
			nq_q <= '0;
		end else if (ctl.sweep) begin
			vq_q <= {vq_upd[0], vq_upd[GRID_DIM-1:1]};
			if (ctl.commit) begin
				fq_q <= {nq_upd[0], nq_upd[GRID_DIM-1:1]};
				nq_q <= '0;
			end else begin
				fq_q <= {fq_q[0], fq_q[GRID_DIM-1:1]};
				nq_q <= {nq_upd[0], nq_upd[GRID_DIM-1:1]};
			end
		end
	end

endmodule

@@ sv/grid_bfs_timed_closures.sv @@
// Shortest route on a grid whose cells close over time.
// req: command 0 writes one cell's closing hour (no result); command 1 asks
// for a route from start to end and gives one result on res.
// cfg: index 0 sets the rows in use, index 1 the columns; always ready.
// A set is a read-modify-write of one grid row in the hour memory.
// A route query first does the bounds and start checks, then one sweep
// over all rows per search level: a row of column cells expands
// the wavefront one row per cycle, fed by one hour-memory row read per cycle.
// One item is worked on at a time; req.ready is high only while idle.
// Results wait in an output register; a new item is taken while a result
// waits, and a finished query holds until the register is free.
// Reset clears the hour memory to never-closing at once (per-row valid
// bits), sets both grid sizes to 64 and empties the output register.
module grid_bfs_timed_closures import gbt_pkg::*; #(
	parameter int GRID_DIM  = GRID_DIM_DEF,
	parameter int HOUR_BITS = HOUR_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	gbt_req_if.sink   req,
	gbt_res_if.source res,
	gbt_cfg_if.sink   cfg
);

`include "grid_bfs_timed_closures_assert.svh"

	localparam int RW    = $clog2(GRID_DIM);
	localparam int ROW_W = GRID_DIM * HOUR_BITS;
	localparam int DW    = ($clog2(GRID_DIM + 1) > CFG_W) ? $clog2(GRID_DIM + 1) : CFG_W;
	localparam int SW    = $clog2(GRID_DIM * GRID_DIM + 1);
	localparam int IW    = (HOUR_BITS > HOUR_IN_W) ? HOUR_BITS : HOUR_IN_W;
	localparam int TW    = (HOUR_BITS > SW) ? HOUR_BITS : SW;
	localparam logic [HOUR_BITS-1:0] NEVER = '1;
	localparam logic [RW-1:0] ROW_LAST = RW'(GRID_DIM - 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SET_WR = 5'b00010,
		ST_Q_CHK  = 5'b00100,
		ST_SWEEP  = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t st_q;
	logic [CFG_W-1:0]     cfg_h_q, cfg_w_q;
	logic [DW-1:0]        h_used, w_used;
	logic [RW-1:0]        x_q, y_q, sx_q, sy_q, ex_q, ey_q, row_q, row_next;
	logic [HOUR_BITS-1:0] hour_q, hour_sat, step_hour;
	logic [SW-1:0]        step_q;
	logic                 any_q, any_lvl, found;
	logic [STATUS_W-1:0]  pend_st_q;
	logic [DIST_W-1:0]    pend_dist_q;
	logic                 out_vld_q;
	logic [STATUS_W-1:0]  out_st_q;
	logic [DIST_W-1:0]    out_dist_q;

	logic                 req_acc, oob, set_ok, start_closed, out_load;
	logic                 rd_en, wr_en;
	logic [RW-1:0]        rd_addr;
	logic [ROW_W-1:0]     rd_row, wr_row;
	cell_ctl_t            ctl;
	logic [GRID_DIM-1:0]  cell_front, cell_new;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_h_q <= CFG_RESET;
			cfg_w_q <= CFG_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == REG_GRID_HEIGHT)
				cfg_h_q <= cfg.data;
			else if (cfg.index == REG_GRID_WIDTH)
				cfg_w_q <= cfg.data;
		end
	end

	assign h_used = (DW'(cfg_h_q) > DW'(GRID_DIM)) ? DW'(GRID_DIM) : DW'(cfg_h_q);
	assign w_used = (DW'(cfg_w_q) > DW'(GRID_DIM)) ? DW'(GRID_DIM) : DW'(cfg_w_q);

	assign req.ready = (st_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;

	assign oob = !(DW'(req.start_x) < w_used) || !(DW'(req.end_x) < w_used) ||
		!(DW'(req.start_y) < h_used) || !(DW'(req.end_y) < h_used);
	assign set_ok = (32'(req.zone_x) < GRID_DIM) && (32'(req.zone_y) < GRID_DIM);
	assign hour_sat = (IW'(req.closing_hour) > IW'(NEVER)) ? NEVER
		: HOUR_BITS'(req.closing_hour);

	assign start_closed = (rd_row[sx_q*HOUR_BITS +: HOUR_BITS] == '0);
	assign row_next     = (row_q == ROW_LAST) ? '0 : row_q + RW'(1);
	assign step_hour    = (TW'(step_q) >= TW'(NEVER)) ? NEVER : HOUR_BITS'(step_q);
	assign any_lvl      = any_q | (|cell_new);
	assign found        = (row_q == ey_q) && cell_new[ex_q];
	assign out_load     = (st_q == ST_DONE) && (!out_vld_q || res.ready);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = row_next;
		wr_en   = 1'b0;
		wr_row  = rd_row;
		wr_row[x_q*HOUR_BITS +: HOUR_BITS] = hour_q;
		case (st_q)
			ST_IDLE: begin
				rd_en   = req_acc && ((req.command == CMD_SET) ? set_ok : !oob);
				rd_addr = (req.command == CMD_SET) ? RW'(req.zone_y) : RW'(req.start_y);
			end
			ST_SET_WR: wr_en = 1'b1;
			ST_Q_CHK: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			ST_SWEEP: rd_en = 1'b1;
			default: rd_en = 1'b0;
		endcase
	end

	always_comb begin
		ctl.clear   = (st_q == ST_Q_CHK);
		ctl.seed    = (st_q == ST_Q_CHK);
		ctl.sweep   = (st_q == ST_SWEEP);
		ctl.commit  = (row_q == ROW_LAST);
		ctl.up_ok   = (row_q != '0);
		ctl.down_ok = (DW'(row_q) + DW'(1)) < h_used;
		ctl.row_ok  = DW'(row_q) < h_used;
	end

	gbt_row_mem #(.GRID_DIM(GRID_DIM), .HOUR_BITS(HOUR_BITS)) u_mem (
		.clk(clk), .arst_n(arst_n),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_row(rd_row),
		.wr_en(wr_en), .wr_addr(y_q), .wr_row(wr_row)
	);

	for (genvar c = 0; c < GRID_DIM; c++) begin : g_cell
		logic left_in, right_in;
		if (c == 0) begin : g_l0
			assign left_in = 1'b0;
		end else begin : g_l
			assign left_in = cell_front[c-1];
		end
		if (c == GRID_DIM - 1) begin : g_r0
			assign right_in = 1'b0;
		end else begin : g_r
			assign right_in = cell_front[c+1];
		end
		gbt_cell #(.GRID_DIM(GRID_DIM), .HOUR_BITS(HOUR_BITS)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.seed_sel(sx_q == RW'(c)), .seed_row(sy_q),
			.col_ok(DW'(c) < w_used),
			.hour(rd_row[c*HOUR_BITS +: HOUR_BITS]), .step_hour(step_hour),
			.left_in(left_in), .right_in(right_in),
			.front_out(cell_front[c]), .new_out(cell_new[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			row_q  <= '0;
			step_q <= '0;
			any_q  <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (req.command == CMD_SET)
							st_q <= set_ok ? ST_SET_WR : ST_IDLE;
						else
							st_q <= oob ? ST_DONE : ST_Q_CHK;
					end
				end
				ST_SET_WR: st_q <= ST_IDLE;
				ST_Q_CHK: begin
					row_q  <= '0;
					step_q <= SW'(1);
					any_q  <= 1'b0;
					if (start_closed || (sx_q == ex_q && sy_q == ey_q))
						st_q <= ST_DONE;
					else
						st_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					row_q <= row_next;
					if (found) begin
						st_q <= ST_DONE;
					end else if (row_q == ROW_LAST) begin
						any_q  <= 1'b0;
						step_q <= step_q + SW'(1);
						if (!any_lvl)
							st_q <= ST_DONE;
					end else begin
						any_q <= any_lvl;
					end
				end
				ST_DONE: begin
					if (out_load)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			x_q    <= RW'(req.zone_x);
			y_q    <= RW'(req.zone_y);
			hour_q <= hour_sat;
			sx_q   <= RW'(req.start_x);
			sy_q   <= RW'(req.start_y);
			ex_q   <= RW'(req.end_x);
			ey_q   <= RW'(req.end_y);
		end
		case (st_q)
			ST_IDLE: begin
				pend_st_q   <= STAT_OUT_OF_BNDS;
				pend_dist_q <= '0;
			end
			ST_Q_CHK: begin
				pend_st_q   <= start_closed ? STAT_START_CLOSE : STAT_FOUND;
				pend_dist_q <= '0;
			end
			ST_SWEEP: begin
				pend_st_q <= found ? STAT_FOUND : STAT_UNREACHABLE;
				if (!found)
					pend_dist_q <= '0;
				else if (32'(step_q) > 32'(DIST_MAX))
					pend_dist_q <= DIST_MAX;
				else
					pend_dist_q <= DIST_W'(step_q);
			end
			default: begin
				pend_st_q   <= pend_st_q;
				pend_dist_q <= pend_dist_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_st_q   <= pend_st_q;
			out_dist_q <= pend_dist_q;
		end
	end

	assign res.valid    = out_vld_q;
	assign res.status   = out_st_q;
	assign res.distance = out_dist_q;

	`GBT_ASSERT_IMPLY(a_sweep_step, clk, arst_n, st_q == ST_SWEEP, step_q != '0)
	`GBT_ASSERT_NEXT(a_set_one_cycle, clk, arst_n, st_q == ST_SET_WR, st_q == ST_IDLE)
	`GBT_ASSERT_IMPLY(a_done_no_read, clk, arst_n, st_q == ST_DONE, !rd_en && !wr_en)

endmodule

@@ sim/grid_bfs_timed_closures_test.sv @@
`timescale 1ns / 100ps

module grid_bfs_timed_closures_test;
	import gbt_pkg::*;

	localparam int CELLS         = GRID_DIM_DEF * GRID_DIM_DEF;
	localparam logic [15:0] NEVER = 16'hFFFF;
	localparam int IDLE_LIMIT    = 400000;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		logic                command;
		logic [5:0]          zx, zy;
		logic [15:0]         hour;
		logic [5:0]          sx, sy, ex, ey;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]    reg_val;
		bit                  typed;
		logic [STATUS_W-1:0] st;
		logic [DIST_W-1:0]   steps;
	} stim_row_t;

	typedef struct {
		logic [STATUS_W-1:0] st;
		logic [DIST_W-1:0]   steps;
	} route_result_t;

	logic clk;
	logic arst_n;

	gbt_req_if req ();
	gbt_res_if res ();
	gbt_cfg_if cfg ();

	grid_bfs_timed_closures u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.res    (res.source),
		.cfg    (cfg.sink)
	);

	// shadow of the block
	logic [15:0]    hour_mem [CELLS];
	bit             seen [CELLS];
	int             wave_cell [CELLS];
	int             wave_step [CELLS];
	logic [CFG_W-1:0] rows_reg, cols_reg;

	route_result_t  pending_routes [$];
	stim_row_t      plan [$];
	int             errors;
	int             idle_cycles;
	bit             res_stalls_on;
	bit             req_gaps_on;
	int             res_hold;

	function automatic int used_dim(logic [CFG_W-1:0] v);
		return (v > GRID_DIM_DEF) ? GRID_DIM_DEF : int'(v);
	endfunction

	function automatic route_result_t route_predict(logic [5:0] sx, logic [5:0] sy,
		logic [5:0] ex, logic [5:0] ey);
		route_result_t r;
		int h, w, head, tail, cur, cx, cy, nstep, goal;
		int nx[4], ny[4];
		h = used_dim(rows_reg);
		w = used_dim(cols_reg);
		r.st = STAT_FOUND;
		r.steps = '0;
		if (sx >= w || ex >= w || sy >= h || ey >= h) begin
			r.st = STAT_OUT_OF_BNDS;
			return r;
		end
		if (hour_mem[sy * GRID_DIM_DEF + sx] == 0) begin
			r.st = STAT_START_CLOSE;
			return r;
		end
		foreach (seen[i]) seen[i] = 0;
		goal = ey * GRID_DIM_DEF + ex;
		seen[sy * GRID_DIM_DEF + sx] = 1;
		wave_cell[0] = sy * GRID_DIM_DEF + sx;
		wave_step[0] = 0;
		head = 0;
		tail = 1;
		while (head < tail) begin
			cur = wave_cell[head];
			nstep = wave_step[head] + 1;
			head++;
			if (cur == goal) begin
				r.steps = (nstep - 1 > DIST_MAX) ? DIST_MAX : DIST_W'(nstep - 1);
				return r;
			end
			cx = cur % GRID_DIM_DEF;
			cy = cur / GRID_DIM_DEF;
			nx = '{cx + 1, cx - 1, cx, cx};
			ny = '{cy, cy, cy - 1, cy + 1};
			for (int k = 0; k < 4; k++) begin
				int c;
				if (nx[k] < 0 || nx[k] >= w || ny[k] < 0 || ny[k] >= h) continue;
				c = ny[k] * GRID_DIM_DEF + nx[k];
				if (seen[c]) continue;
				if (!(hour_mem[c] == NEVER || hour_mem[c] > nstep)) continue;
				seen[c] = 1;
				wave_cell[tail] = c;
				wave_step[tail] = nstep;
				tail++;
			end
		end
		r.st = STAT_UNREACHABLE;
		return r;
	endfunction

	function automatic stim_row_t set_row(int x, int y, logic [15:0] hr);
		stim_row_t r;
		r = '{kind: ROW_ITEM, default: '0};
		r.kind = ROW_ITEM;
		r.command = CMD_SET;
		r.zx = 6'(x);
		r.zy = 6'(y);
		r.hour = hr;
		r.sx = 6'($urandom);
		r.sy = 6'($urandom);
		r.ex = 6'($urandom);
		r.ey = 6'($urandom);
		return r;
	endfunction

	function automatic stim_row_t route_row(int sx, int sy, int ex, int ey,
		bit typed = 0, logic [STATUS_W-1:0] st = STAT_FOUND, int d = 0);
		stim_row_t r;
		r = '{kind: ROW_ITEM, default: '0};
		r.kind = ROW_ITEM;
		r.command = CMD_ROUTE;
		r.zx = 6'($urandom);
		r.zy = 6'($urandom);
		r.hour = 16'($urandom);
		r.sx = 6'(sx);
		r.sy = 6'(sy);
		r.ex = 6'(ex);
		r.ey = 6'(ey);
		r.typed = typed;
		r.st = st;
		r.steps = DIST_W'(d);
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int v);
		stim_row_t r;
		r = '{kind: ROW_CFG, default: '0};
		r.kind = ROW_CFG;
		r.reg_idx = idx;
		r.reg_val = CFG_W'(v);
		return r;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int pick_dim();
		int p;
		p = $urandom_range(0, 99);
		if (p < 80) return $urandom_range(1, 10);
		if (p < 90) return 64;
		return $urandom_range(65, 127);
	endfunction

	function automatic stim_row_t random_item();
		int h, w, p;
		logic [15:0] hr;
		h = used_dim(rows_reg);
		w = used_dim(cols_reg);
		if (h == 0) h = 1;
		if (w == 0) w = 1;
		p = $urandom_range(0, 99);
		if (p < 50) begin
			case ($urandom_range(0, 3))
				0, 1: hr = 16'($urandom_range(0, 12));
				2:    hr = NEVER;
				default: hr = 16'($urandom);
			endcase
			if ($urandom_range(0, 9) < 8)
				return set_row($urandom_range(0, w - 1), $urandom_range(0, h - 1), hr);
			return set_row($urandom_range(0, 63), $urandom_range(0, 63), hr);
		end
		if ($urandom_range(0, 9) < 9)
			return route_row($urandom_range(0, w - 1), $urandom_range(0, h - 1),
				$urandom_range(0, w - 1), $urandom_range(0, h - 1));
		return route_row($urandom_range(0, 63), $urandom_range(0, 63),
			$urandom_range(0, 63), $urandom_range(0, 63));
	endfunction

	task automatic drain();
		while (pending_routes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		if (idx == REG_GRID_HEIGHT) rows_reg = v;
		else if (idx == REG_GRID_WIDTH) cols_reg = v;
		cfg.valid <= 1'b0;
	endtask

	task automatic send_item(stim_row_t r);
		route_result_t e;
		int g;
		req.valid <= 1'b1;
		req.command <= r.command;
		req.zone_x <= r.zx;
		req.zone_y <= r.zy;
		req.closing_hour <= r.hour;
		req.start_x <= r.sx;
		req.start_y <= r.sy;
		req.end_x <= r.ex;
		req.end_y <= r.ey;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		if (r.command == CMD_SET) begin
			hour_mem[r.zy * GRID_DIM_DEF + r.zx] = r.hour;
		end else begin
			if (r.typed) begin
				e.st = r.st;
				e.steps = r.steps;
			end else begin
				e = route_predict(r.sx, r.sy, r.ex, r.ey);
			end
			pending_routes.push_back(e);
		end
		g = req_gaps_on ? gap_len() : 0;
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (res_hold > 0) begin
			res_hold--;
			res.ready <= 1'b0;
		end else if (res_stalls_on && $urandom_range(0, 99) < 12) begin
			res_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 3);
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (pending_routes.size() == 0) begin
				$display("%0t: result with none expected: status %0d distance %0d",
					$time, res.status, res.distance);
				errors++;
			end else begin
				route_result_t e;
				e = pending_routes.pop_front();
				if (res.status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, res.status);
					errors++;
				end
				if (res.distance !== e.steps) begin
					$display("%0t: distance expected %0d actual %0d",
						$time, e.steps, res.distance);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (res.valid && res.ready)
			|| (cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		stim_row_t r;
		int n_items;
		errors = 0;
		idle_cycles = 0;
		res_hold = 0;
		res_stalls_on = 1;
		req_gaps_on = 1;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.command = CMD_SET;
		req.zone_x = '0;
		req.zone_y = '0;
		req.closing_hour = '0;
		req.start_x = '0;
		req.start_y = '0;
		req.end_x = '0;
		req.end_y = '0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_GRID_HEIGHT;
		cfg.data = '0;
		foreach (hour_mem[i]) hour_mem[i] = NEVER;
		rows_reg = CFG_RESET;
		cols_reg = CFG_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		plan.push_back(route_row(0, 0, 0, 0, 1, STAT_FOUND, 0));
		plan.push_back(route_row(63, 63, 63, 63, 1, STAT_FOUND, 0));
		plan.push_back(route_row(0, 0, 1, 0, 1, STAT_FOUND, 1));
		plan.push_back(route_row(0, 0, 63, 0, 1, STAT_FOUND, 63));
		plan.push_back(set_row(5, 5, 16'h0000));
		plan.push_back(route_row(5, 5, 5, 5, 1, STAT_START_CLOSE, 0));
		plan.push_back(set_row(63, 63, 16'h0000));
		plan.push_back(route_row(0, 0, 63, 63, 1, STAT_UNREACHABLE, 0));
		plan.push_back(set_row(63, 63, 16'hFFFE));
		plan.push_back(set_row(1, 0, 16'h0001));
		plan.push_back(route_row(0, 0, 2, 0));
		plan.push_back(route_row(63, 63, 0, 0));
		plan.push_back(cfg_row(REG_GRID_HEIGHT, 1));
		plan.push_back(cfg_row(REG_GRID_WIDTH, 1));
		plan.push_back(route_row(0, 0, 0, 0, 1, STAT_FOUND, 0));
		plan.push_back(route_row(1, 0, 0, 0, 1, STAT_OUT_OF_BNDS, 0));
		plan.push_back(route_row(0, 0, 0, 1, 1, STAT_OUT_OF_BNDS, 0));
		plan.push_back(cfg_row(REG_GRID_HEIGHT, 0));
		plan.push_back(cfg_row(REG_GRID_WIDTH, 127));
		plan.push_back(route_row(0, 0, 0, 0, 1, STAT_OUT_OF_BNDS, 0));
		plan.push_back(cfg_row(REG_GRID_HEIGHT, 127));
		plan.push_back(cfg_row(REG_GRID_WIDTH, 0));
		plan.push_back(route_row(0, 0, 0, 0, 1, STAT_OUT_OF_BNDS, 0));
		plan.push_back(cfg_row(REG_GRID_WIDTH, 64));
		plan.push_back(route_row(62, 63, 63, 62));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				req.valid <= 1'b0;
				drain();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_item(plan[i]);
			end
		end

		// random phases
		n_items = 0;
		for (int ph = 0; ph < 5; ph++) begin
			req.valid <= 1'b0;
			drain();
			write_reg(REG_GRID_HEIGHT, CFG_W'(pick_dim()));
			write_reg(REG_GRID_WIDTH, CFG_W'(pick_dim()));
			res_stalls_on = (ph != 3);
			req_gaps_on = (ph != 4);
			for (int k = 0; k < 15; k++) begin
				if (ph == 2 && k == 7) begin
					req.valid <= 1'b0;
					drain();
				end
				r = random_item();
				send_item(r);
				n_items++;
			end
		end
		req.valid <= 1'b0;

		while (pending_routes.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
